// ===== rtl/tcce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console engine
// screen geometry, control codes, payload words, controller command/status
// ----------------------------------------------------------------------------
package tcce_pkg;

  // screen store geometry
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned CELLS    = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W   = $clog2(CELLS);
  localparam int unsigned PTR_W    = ADDR_W + 1;

  // field widths
  localparam int unsigned GEO_W  = 7;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 16;
  localparam int unsigned CELL_W = 32;

  localparam logic [GEO_W-1:0] MAX_COLS_G = GEO_W'(MAX_COLS);
  localparam logic [GEO_W-1:0] MAX_ROWS_G = GEO_W'(MAX_ROWS);
  localparam logic [GEO_W-1:0] COLS_RESET = 7'd48;
  localparam logic [GEO_W-1:0] ROWS_RESET = 7'd35;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE = 2'd2;

  // character and control codes
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h91;
  localparam logic [CHAR_W-1:0] CH_UP    = 8'h90;
  localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h93;
  localparam logic [CHAR_W-1:0] CH_DOWN  = 8'h92;
  localparam logic [CHAR_W-1:0] CH_HOME  = 8'h94;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h99;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_CLEAR = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // input and result words
  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [11:0]       read_addr;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_col;
    logic [11:0]       cursor_pos;
    logic [CELL_W-1:0] read_data;
  } result_t;

  // character class
  typedef enum logic [3:0] {
    CHR_PRINT,
    CHR_CR,
    CHR_LF,
    CHR_RIGHT,
    CHR_UP,
    CHR_LEFT,
    CHR_DOWN,
    CHR_HOME,
    CHR_DEL,
    CHR_BS,
    CHR_CLEAR,
    CHR_TAB
  } chr_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_READ,
    OP_CAPTURE,
    OP_SAT,
    OP_MOVE,
    OP_PUT,
    OP_SCROLL_SET,
    OP_DEL_SET,
    OP_CLR_SET,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_FILL,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    chr_e chr;
    logic at_bottom;
    logic col_zero;
    logic put_wraps;
    logic copy_done;
    logic fill_done;
  } stat_t;

  function automatic chr_e chr_decode(logic [CHAR_W-1:0] c);
    chr_e k;
    case (c)
      CH_CR:    k = CHR_CR;
      CH_LF:    k = CHR_LF;
      CH_RIGHT: k = CHR_RIGHT;
      CH_UP:    k = CHR_UP;
      CH_LEFT:  k = CHR_LEFT;
      CH_DOWN:  k = CHR_DOWN;
      CH_HOME:  k = CHR_HOME;
      CH_DEL:   k = CHR_DEL;
      CH_BS:    k = CHR_BS;
      CH_CLEAR: k = CHR_CLEAR;
      CH_TAB:   k = CHR_TAB;
      default:  k = CHR_PRINT;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/tcce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/tcce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl: sequencer of the text console engine
// walks one item through decode, cell writes and memory sweeps
// ----------------------------------------------------------------------------
module tcce_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            action_i,
  input  tcce_pkg::stat_t stat_i,
  output tcce_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  typedef enum logic [13:0] {
    S_BOOT    = 14'h0001,
    S_IDLE    = 14'h0002,
    S_READ    = 14'h0004,
    S_CAP     = 14'h0008,
    S_SAT     = 14'h0010,
    S_EXEC    = 14'h0020,
    S_PUT     = 14'h0040,
    S_SCROLL  = 14'h0080,
    S_DELSET  = 14'h0100,
    S_CLRSET  = 14'h0200,
    S_COPY_RD = 14'h0400,
    S_COPY_WR = 14'h0800,
    S_FILL    = 14'h1000,
    S_FIN     = 14'h2000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] rem_q, rem_d;

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    cmd_o.op  = tcce_pkg::OP_NONE;
    case (state_q)
      S_BOOT: begin
        if (stat_i.fill_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = tcce_pkg::OP_FILL;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = tcce_pkg::OP_LATCH;
          state_d  = action_i ? S_READ : S_SAT;
        end
      end
      S_READ: begin
        cmd_o.op = tcce_pkg::OP_READ;
        state_d  = S_CAP;
      end
      S_CAP: begin
        cmd_o.op = tcce_pkg::OP_CAPTURE;
        state_d  = S_FIN;
      end
      S_SAT: begin
        cmd_o.op = tcce_pkg::OP_SAT;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.op = tcce_pkg::OP_MOVE;
        rem_d    = 2'd0;
        case (stat_i.chr)
          tcce_pkg::CHR_LF:    state_d = stat_i.at_bottom ? S_SCROLL : S_FIN;
          tcce_pkg::CHR_DEL:   state_d = S_DELSET;
          tcce_pkg::CHR_BS:    state_d = stat_i.col_zero ? S_FIN : S_DELSET;
          tcce_pkg::CHR_CLEAR: state_d = S_CLRSET;
          tcce_pkg::CHR_TAB: begin
            rem_d   = 2'd3;
            state_d = S_PUT;
          end
          tcce_pkg::CHR_PRINT: state_d = S_PUT;
          default:             state_d = S_FIN;
        endcase
      end
      S_PUT: begin
        cmd_o.op = tcce_pkg::OP_PUT;
        if (stat_i.put_wraps && stat_i.at_bottom) begin
          state_d = S_SCROLL;
        end else if (rem_q != 2'd0) begin
          rem_d   = rem_q - 2'd1;
          state_d = S_PUT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCROLL: begin
        cmd_o.op = tcce_pkg::OP_SCROLL_SET;
        state_d  = S_COPY_RD;
      end
      S_DELSET: begin
        cmd_o.op = tcce_pkg::OP_DEL_SET;
        state_d  = S_COPY_RD;
      end
      S_CLRSET: begin
        cmd_o.op = tcce_pkg::OP_CLR_SET;
        state_d  = S_COPY_RD;
      end
      S_COPY_RD: begin
        if (stat_i.copy_done) begin
          state_d = S_FILL;
        end else begin
          cmd_o.op = tcce_pkg::OP_COPY_RD;
          state_d  = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd_o.op = tcce_pkg::OP_COPY_WR;
        state_d  = S_COPY_RD;
      end
      S_FILL: begin
        if (!stat_i.fill_done) begin
          cmd_o.op = tcce_pkg::OP_FILL;
        end else if (rem_q != 2'd0) begin
          rem_d   = rem_q - 2'd1;
          state_d = S_PUT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = tcce_pkg::OP_RESULT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      rem_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/tcce_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_dp: datapath of the text console engine
// geometry and attribute registers, cursor, sweep pointer and screen ram
// ----------------------------------------------------------------------------
module tcce_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tcce_pkg::cmd_t                     cmd_i,
  output tcce_pkg::stat_t                    stat_o,
  input  tcce_pkg::item_t                    item_i,
  input  logic                               cfg_we_i,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tcce_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output logic                               done_o,
  output tcce_pkg::result_t                  result_o
);

  localparam int unsigned GW = tcce_pkg::GEO_W;
  localparam int unsigned PW = tcce_pkg::PTR_W;
  localparam int unsigned AW = tcce_pkg::ADDR_W;
  localparam int unsigned RW = tcce_pkg::POS_W;
  localparam int unsigned CW = tcce_pkg::CELL_W;

  // configuration
  logic [GW-1:0]               cols_q, rows_q;
  logic [tcce_pkg::ATTR_W-1:0] attr_q;
  logic [GW-1:0]               cols, rows;

  // cursor
  logic [RW-1:0] row_q, col_q;

  // latched item and read data
  logic [tcce_pkg::CHAR_W-1:0] char_q;
  logic [11:0]                 raddr_q;
  logic [CW-1:0]               data_q;

  // sweep engine
  logic [PW-1:0] ptr_q, copy_end_q, fill_end_q;
  logic [GW-1:0] stride_q;
  logic [CW-1:0] fill_word_q;

  // derived values
  logic [PW-1:0]   row_base, cur_addr, scroll_end, area, src_addr;
  logic [CW-1:0]   blank, put_word;
  tcce_pkg::chr_e  chr;
  logic            at_bottom, col_zero, put_wraps;

  // ram
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  // 0 acts as 1, values above the store size saturate
  always_comb begin
    cols = cols_q;
    if (cols_q == '0) begin
      cols = GW'(1);
    end else if (cols_q > tcce_pkg::MAX_COLS_G) begin
      cols = tcce_pkg::MAX_COLS_G;
    end
    rows = rows_q;
    if (rows_q == '0) begin
      rows = GW'(1);
    end else if (rows_q > tcce_pkg::MAX_ROWS_G) begin
      rows = tcce_pkg::MAX_ROWS_G;
    end
  end

  assign chr       = tcce_pkg::chr_decode(char_q);
  assign at_bottom = (GW'(row_q) + GW'(1)) >= rows;
  assign put_wraps = (GW'(col_q) + GW'(1)) >= cols;
  assign col_zero  = (col_q == '0);

  assign row_base   = PW'(row_q) * PW'(cols);
  assign cur_addr   = row_base + PW'(col_q);
  assign scroll_end = PW'(cols) * PW'(rows - GW'(1));
  assign area       = PW'(cols) * PW'(rows);
  assign src_addr   = ptr_q + PW'(stride_q);

  assign blank    = {attr_q, 8'h00, tcce_pkg::CH_SPACE};
  assign put_word = {attr_q, 8'h00,
                     (chr == tcce_pkg::CHR_TAB) ? tcce_pkg::CH_SPACE : char_q};

  assign stat_o.chr       = chr;
  assign stat_o.at_bottom = at_bottom;
  assign stat_o.col_zero  = col_zero;
  assign stat_o.put_wraps = put_wraps;
  assign stat_o.copy_done = (ptr_q == copy_end_q);
  assign stat_o.fill_done = (ptr_q == fill_end_q);

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tcce_pkg::COLS_RESET;
      rows_q <= tcce_pkg::ROWS_RESET;
      attr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcce_pkg::CFG_TEXT_COLS: cols_q <= cfg_data_i[GW-1:0];
        tcce_pkg::CFG_TEXT_ROWS: rows_q <= cfg_data_i[GW-1:0];
        tcce_pkg::CFG_ATTRIBUTE: attr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      case (cmd_i.op)
        tcce_pkg::OP_SAT: begin
          if (GW'(row_q) >= rows) row_q <= RW'(rows - GW'(1));
          if (GW'(col_q) >= cols) col_q <= RW'(cols - GW'(1));
        end
        tcce_pkg::OP_MOVE: begin
          case (chr)
            tcce_pkg::CHR_CR: col_q <= '0;
            tcce_pkg::CHR_LF, tcce_pkg::CHR_DOWN: begin
              if (!at_bottom) row_q <= row_q + RW'(1);
            end
            tcce_pkg::CHR_RIGHT: begin
              if (!put_wraps) col_q <= col_q + RW'(1);
            end
            tcce_pkg::CHR_UP: begin
              if (row_q != '0) row_q <= row_q - RW'(1);
            end
            tcce_pkg::CHR_LEFT, tcce_pkg::CHR_BS: begin
              if (!col_zero) col_q <= col_q - RW'(1);
            end
            tcce_pkg::CHR_HOME: begin
              if (col_zero) row_q <= '0;
              col_q <= '0;
            end
            default: ;
          endcase
        end
        tcce_pkg::OP_CLR_SET: begin
          row_q <= '0;
          col_q <= '0;
        end
        tcce_pkg::OP_PUT: begin
          if (put_wraps) begin
            col_q <= '0;
            if (!at_bottom) row_q <= row_q + RW'(1);
          end else begin
            col_q <= col_q + RW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // sweep pointer: copy from ptr+stride, then fill up to the fill end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      copy_end_q  <= '0;
      fill_end_q  <= PW'(tcce_pkg::CELLS);
      stride_q    <= '0;
      fill_word_q <= '0;
    end else begin
      case (cmd_i.op)
        tcce_pkg::OP_SCROLL_SET: begin
          ptr_q       <= '0;
          copy_end_q  <= scroll_end;
          fill_end_q  <= scroll_end + PW'(cols);
          stride_q    <= cols;
          fill_word_q <= blank;
        end
        tcce_pkg::OP_DEL_SET: begin
          ptr_q       <= cur_addr;
          copy_end_q  <= row_base + PW'(cols) - PW'(1);
          fill_end_q  <= row_base + PW'(cols);
          stride_q    <= GW'(1);
          fill_word_q <= blank;
        end
        tcce_pkg::OP_CLR_SET: begin
          ptr_q       <= '0;
          copy_end_q  <= '0;
          fill_end_q  <= area;
          fill_word_q <= blank;
        end
        tcce_pkg::OP_COPY_WR, tcce_pkg::OP_FILL: ptr_q <= ptr_q + PW'(1);
        default: ;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tcce_pkg::OP_LATCH) begin
      char_q  <= item_i.char_code;
      raddr_q <= item_i.read_addr;
      data_q  <= '0;
    end else if (cmd_i.op == tcce_pkg::OP_CAPTURE) begin
      data_q  <= ram_rdata;
    end
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (cmd_i.op == tcce_pkg::OP_RESULT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tcce_pkg::OP_RESULT) begin
      result_o.cursor_row <= row_q;
      result_o.cursor_col <= col_q;
      result_o.cursor_pos <= cur_addr[11:0];
      result_o.read_data  <= data_q;
    end
  end

  // ram ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = fill_word_q;
    case (cmd_i.op)
      tcce_pkg::OP_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr[AW-1:0];
        ram_wdata = put_word;
      end
      tcce_pkg::OP_COPY_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      tcce_pkg::OP_FILL: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign ram_re    = (cmd_i.op == tcce_pkg::OP_READ) || (cmd_i.op == tcce_pkg::OP_COPY_RD);
  assign ram_raddr = (cmd_i.op == tcce_pkg::OP_READ) ? AW'(raddr_q) : src_addr[AW-1:0];

  tcce_ram #(
    .WIDTH (CW),
    .DEPTH (tcce_pkg::CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== rtl/text_console_char_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine: text console character engine
// keeps a screen of attribute/character cells and a cursor; prints
// characters, handles control codes and reads back single cells
// ----------------------------------------------------------------------------
//  channel   handshake                 word
//  item      start_i, busy_o           item_i   (action, char_code, read_addr)
//  result    done_o strobe, no stall   result_o (cursor row/col/pos, read_data)
//  config    cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
//  an item is taken when start_i is high and busy_o low; its result word
//  is held on result_o, flagged by done_o for a single cycle. a cell read
//  steps through read, capture and result; a cursor or arrow code through
//  saturate, move and result; a character puts one cell, a tab four blanks.
//  scroll copies every cell up a row and blanks the last row; delete shifts
//  the row left from the cursor; clear blanks rows*cols cells. the single
//  port-pair screen ram fills one cell per cycle, copies one per read/write
//  pair. after reset a clearing pass zeroes all 4096 cells (busy_o high);
//  config writes are taken only while busy_o is low.
// ----------------------------------------------------------------------------
module text_console_char_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item side
  input  logic                               start_i,
  output logic                               busy_o,
  input  tcce_pkg::item_t                    item_i,
  // result side
  output logic                               done_o,
  output tcce_pkg::result_t                  result_o,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tcce_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  tcce_pkg::cmd_t  cmd;
  tcce_pkg::stat_t stat;

  // registers change only while no item is in flight
  assign cfg_ready_o = !busy_o;

  // sequencer: decodes the item and steps the datapath
  tcce_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (item_i.action),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath: cursor, sweep engine, screen ram and result register
  tcce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // result strobe comes as the sequencer drops back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // the strobe follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without work");

  // an accepted item makes the engine busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted but engine not busy");

  // one strobe per item
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text console character engine
// a queue of planned steps (items, register writes, drain points) feeds a
// clocked driver; a clocked monitor predicts every result word from its own
// copy of the screen, cursor and registers and checks each word field by field
// ----------------------------------------------------------------------------
module testbench;
  import tcce_pkg::*;

  // item action codes
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_READ = 1'b1;
  // register index past the end of the list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned IDLE_PCT      = 38;   // sender idle chance per cycle
  localparam int unsigned CALM_FIRST    = 200;  // words in this span never idle
  localparam int unsigned CALM_LAST     = 300;
  localparam int unsigned WORD_TARGET   = 450;
  localparam int unsigned SETTLE_CYCLES = 8;    // quiet time before register writes
  localparam int unsigned END_CYCLES    = 16;   // quiet time before the verdict

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e             kind;
    item_t                  word;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   data;
    logic                   calm;   // no random idling ahead of this word
  } step_t;

  // dut connections, all inputs known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  item_t                item      = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 busy;
  logic                 done;
  result_t              result;
  logic                 cfg_ready;

  // planned stimulus and bookkeeping
  step_t            plan_q[$];
  result_t          pending_reports_q[$];
  int unsigned      items_planned = 0;
  int unsigned      items_offered = 0;
  int unsigned      items_taken   = 0;
  int unsigned      cfgs_offered  = 0;
  int unsigned      cfgs_taken    = 0;
  int unsigned      hold_cycles   = 0;
  int unsigned      fail_cnt      = 0;
  logic             busy_seen     = 1'b1;
  longint unsigned  cycle_cnt     = 0;
  longint unsigned  cycle_budget  = 0;
  longint unsigned  cycle_limit   = 64'd100_000_000;

  // geometry in force while the plan is built, used to size the time limit
  int unsigned plan_cols = 48;
  int unsigned plan_rows = 35;

  // console shadow: screen, cursor and registers
  logic [CELL_W-1:0] screen_model [0:CELLS-1];
  int unsigned       cur_row  = 0;
  int unsigned       cur_col  = 0;
  logic [GEO_W-1:0]  cols_cfg = COLS_RESET;
  logic [GEO_W-1:0]  rows_cfg = ROWS_RESET;
  logic [ATTR_W-1:0] attr_cfg = '0;

  initial begin
    for (int n = 0; n < CELLS; n++) screen_model[n] = '0;
  end

  text_console_char_engine u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .item_i      (item),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------- shadow --

  // zero reads as one, anything past the store size saturates
  function automatic int unsigned fit_geometry(input logic [GEO_W-1:0] g,
                                               input int unsigned top);
    if (g == '0) return 1;
    if (g > top) return top;
    return g;
  endfunction

  function automatic logic [CELL_W-1:0] paint(input logic [CHAR_W-1:0] ch);
    return {attr_cfg, 8'h00, ch};
  endfunction

  // down one row, scroll the used area up and blank the last row at the bottom
  function automatic void line_feed(input int unsigned c, input int unsigned r);
    if (cur_row + 1 < r) begin
      cur_row++;
    end else begin
      cur_row = r - 1;
      for (int n = 0; n < c * (r - 1); n++) screen_model[n] = screen_model[n + c];
      for (int n = 0; n < c; n++) screen_model[c * (r - 1) + n] = paint(CH_SPACE);
    end
  endfunction

  function automatic void put_glyph(input logic [CHAR_W-1:0] ch,
                                    input int unsigned c, input int unsigned r);
    screen_model[cur_row * c + cur_col] = paint(ch);
    cur_col++;
    if (cur_col >= c) begin
      cur_col = 0;
      line_feed(c, r);
    end
  endfunction

  // close the gap at the cursor, the row end gets a blank
  function automatic void shift_row_left(input int unsigned c);
    int unsigned base;
    base = cur_row * c;
    for (int n = cur_col; n + 1 < c; n++) screen_model[base + n] = screen_model[base + n + 1];
    screen_model[base + c - 1] = paint(CH_SPACE);
  endfunction

  // applies one item word to the shadow and returns the result word it must give
  function automatic result_t console_report(input item_t w);
    int unsigned c;
    int unsigned r;
    result_t     rep;
    c = fit_geometry(cols_cfg, MAX_COLS);
    r = fit_geometry(rows_cfg, MAX_ROWS);
    rep.read_data = '0;
    if (w.action == ACT_READ) begin
      // a read leaves the cursor as stored, even outside a shrunk screen
      rep.read_data = screen_model[w.read_addr];
    end else begin
      // pull a stale cursor back inside the geometry first
      if (cur_row >= r) cur_row = r - 1;
      if (cur_col >= c) cur_col = c - 1;
      case (w.char_code)
        CH_CR:    cur_col = 0;
        CH_LF:    line_feed(c, r);
        CH_RIGHT: if (cur_col + 1 < c) cur_col++;
        CH_UP:    if (cur_row > 0) cur_row--;
        CH_LEFT:  if (cur_col > 0) cur_col--;
        CH_DOWN:  if (cur_row + 1 < r) cur_row++;
        CH_HOME: begin
          if (cur_col == 0) cur_row = 0;
          cur_col = 0;
        end
        CH_DEL:   shift_row_left(c);
        CH_BS: begin
          if (cur_col > 0) begin
            cur_col--;
            shift_row_left(c);
          end
        end
        CH_CLEAR: begin
          for (int n = 0; n < r * c; n++) screen_model[n] = paint(CH_SPACE);
          cur_row = 0;
          cur_col = 0;
        end
        CH_TAB:   repeat (4) put_glyph(CH_SPACE, c, r);
        default:  put_glyph(w.char_code, c, r);
      endcase
    end
    rep.cursor_row = POS_W'(cur_row);
    rep.cursor_col = POS_W'(cur_col);
    rep.cursor_pos = 12'(cur_row * c + cur_col);
    return rep;
  endfunction

  // ------------------------------------------------------------------ plan --

  task automatic push_word(input item_t w);
    step_t       s;
    int unsigned area;
    logic        cheap;
    area   = plan_cols * plan_rows;
    s.kind = STEP_ITEM;
    s.word = w;
    s.idx  = '0;
    s.data = '0;
    s.calm = (items_planned >= CALM_FIRST) && (items_planned < CALM_LAST);
    plan_q.push_back(s);
    items_planned++;
    // cursor moves and reads never walk memory; the rest may scroll, up to
    // four times for a tab on a one-column screen
    cheap = (w.action == ACT_READ);
    case (w.char_code)
      CH_CR, CH_RIGHT, CH_UP, CH_LEFT, CH_DOWN, CH_HOME: cheap = 1'b1;
      default: ;
    endcase
    if (cheap) cycle_budget += 32;
    else       cycle_budget += 4 * (2 * area + plan_cols) + area + 2 * plan_cols + 64;
  endtask

  task automatic plan_char(input logic [CHAR_W-1:0] ch);
    item_t w;
    w.action    = ACT_CHAR;
    w.char_code = ch;
    w.read_addr = 12'($urandom);
    push_word(w);
  endtask

  task automatic plan_read(input logic [11:0] addr);
    item_t w;
    w.action    = ACT_READ;
    w.char_code = CHAR_W'($urandom);
    w.read_addr = addr;
    push_word(w);
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    step_t s;
    s.kind = STEP_CFG;
    s.word = '0;
    s.idx  = idx;
    s.data = data;
    s.calm = 1'b1;
    plan_q.push_back(s);
    if (idx == CFG_TEXT_COLS) plan_cols = fit_geometry(data[GEO_W-1:0], MAX_COLS);
    if (idx == CFG_TEXT_ROWS) plan_rows = fit_geometry(data[GEO_W-1:0], MAX_ROWS);
  endtask

  // sender holds until every result word is in and the engine is idle
  task automatic plan_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    s.word = '0;
    s.idx  = '0;
    s.data = '0;
    s.calm = 1'b1;
    plan_q.push_back(s);
    cycle_budget += SETTLE_CYCLES + 16;
  endtask

  // -------------------------------------------------------------- stimulus --

  initial begin : stimulus
    int unsigned roll;
    int unsigned words;
    int unsigned cols_v;
    int unsigned rows_v;

    // first drain also covers the clearing pass after reset
    plan_drain();

    // 8 x 4 screen; upper data bits set, the registers keep only 7 bits
    plan_cfg(CFG_TEXT_COLS, 16'hFF88);
    plan_cfg(CFG_TEXT_ROWS, 16'hFF84);
    plan_cfg(CFG_ATTRIBUTE, 16'hFFFF);
    plan_cfg(CFG_UNUSED, 16'hFFFF);
    plan_char(8'h41);
    plan_char(8'h00);
    plan_char(8'hFF);
    plan_char(8'h7F);
    plan_char(CH_TAB);              // fills the row and wraps
    plan_char(CH_RIGHT);
    plan_char(CH_RIGHT);
    plan_char(CH_LEFT);
    plan_char(CH_DOWN);
    plan_char(CH_UP);
    plan_char(CH_HOME);             // column off zero: column only
    plan_char(CH_HOME);             // column at zero: row too
    plan_char(CH_DEL);
    plan_char(CH_RIGHT);
    plan_char(CH_BS);
    plan_char(CH_BS);               // at column zero: nothing happens
    plan_char(CH_CR);
    plan_read(12'd0);
    plan_read(12'd7);
    plan_read(12'hFFF);
    repeat (4) plan_char(CH_LF);    // last one scrolls
    plan_char(CH_CLEAR);
    plan_read(12'd5);

    // zero geometry acts as a single cell: every print scrolls
    plan_drain();
    plan_cfg(CFG_TEXT_COLS, 16'h0000);
    plan_cfg(CFG_TEXT_ROWS, 16'h0080);
    plan_cfg(CFG_ATTRIBUTE, 16'h0000);
    plan_char(8'h5A);
    plan_char(CH_TAB);
    plan_char(CH_LEFT);
    plan_read(12'd0);

    // largest screen, columns saturate; walk down and scroll the whole store
    plan_drain();
    plan_cfg(CFG_TEXT_COLS, 16'h007F);
    plan_cfg(CFG_TEXT_ROWS, 16'h0040);
    plan_cfg(CFG_ATTRIBUTE, 16'h5A3C);
    plan_char(CH_CLEAR);
    repeat (63) plan_char(CH_DOWN);
    plan_char(CH_LF);
    plan_char(8'h78);
    plan_read(12'd4095);
    plan_read(12'd4032);

    // shrink under the cursor: a read keeps it, a character pulls it in
    plan_drain();
    plan_cfg(CFG_TEXT_COLS, 16'h0005);
    plan_cfg(CFG_TEXT_ROWS, 16'h0003);
    plan_read(12'd0);
    plan_char(CH_RIGHT);

    // random phases, mostly small screens so scrolls stay short
    while (items_planned < WORD_TARGET) begin
      plan_drain();
      roll = $urandom_range(99);
      if (roll < 8) begin
        cols_v = $urandom_range(40, 127);
        rows_v = $urandom_range(40, 127);
        words  = 6;
      end else if (roll < 16) begin
        cols_v = $urandom_range(0, 2);
        rows_v = $urandom_range(0, 2);
        words  = 12;
      end else begin
        cols_v = $urandom_range(1, 16);
        rows_v = $urandom_range(1, 8);
        words  = $urandom_range(10, 30);
      end
      plan_cfg(CFG_TEXT_COLS, {9'($urandom), 7'(cols_v)});
      plan_cfg(CFG_TEXT_ROWS, {9'($urandom), 7'(rows_v)});
      if ($urandom_range(9) < 7) plan_cfg(CFG_ATTRIBUTE, 16'($urandom));
      if ($urandom_range(9) < 1) plan_cfg(CFG_UNUSED, 16'($urandom));
      for (int k = 0; k < words; k++) begin
        roll = $urandom_range(99);
        if (roll < 14) begin
          if ($urandom_range(9) < 7) plan_read(12'($urandom_range(plan_cols * plan_rows - 1)));
          else plan_read(12'($urandom));
        end else if (roll < 50) begin
          plan_char(8'($urandom));
        end else if (roll < 58) begin
          plan_char(CH_LF);
        end else if (roll < 62) begin
          plan_char(CH_CR);
        end else if (roll < 76) begin
          case ($urandom_range(3))
            0:       plan_char(CH_RIGHT);
            1:       plan_char(CH_UP);
            2:       plan_char(CH_LEFT);
            default: plan_char(CH_DOWN);
          endcase
        end else if (roll < 80) begin
          plan_char(CH_HOME);
        end else if (roll < 85) begin
          plan_char(CH_DEL);
        end else if (roll < 91) begin
          plan_char(CH_BS);
        end else if (roll < 95) begin
          plan_char(CH_TAB);
        end else begin
          plan_char(CH_CLEAR);
        end
      end
    end

    // worst case taken four times over, plus the clearing pass
    cycle_limit = 4 * cycle_budget + 4 * CELLS + 10000;

    // hold reset, then release it on a falling edge, away from the rising edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every word handed over and every result word checked
    do @(negedge clk);
    while (plan_q.size() != 0 || items_taken != items_planned ||
           pending_reports_q.size() != 0);
    repeat (END_CYCLES) @(negedge clk);

    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- driver --

  // drives on the falling edge; a word stays up until the monitor counts it in
  always @(negedge clk) begin : feed
    logic item_wait;
    logic cfg_wait;
    logic nx_start;
    logic nx_cfg;
    item_wait = start && (items_taken != items_offered);
    cfg_wait  = cfg_valid && (cfgs_taken != cfgs_offered);
    nx_start  = item_wait;
    nx_cfg    = cfg_wait;
    if (rst_n && !item_wait && !cfg_wait) begin
      if (hold_cycles != 0) begin
        hold_cycles--;
      end else if (plan_q.size() != 0) begin
        case (plan_q[0].kind)
          STEP_ITEM: begin
            // random idling, except inside the calm stretch
            if (plan_q[0].calm || $urandom_range(99) >= IDLE_PCT) begin
              item <= plan_q[0].word;
              nx_start = 1'b1;
              items_offered++;
              plan_q.delete(0);
            end
          end
          STEP_CFG: begin
            cfg_index <= plan_q[0].idx;
            cfg_data  <= plan_q[0].data;
            nx_cfg = 1'b1;
            cfgs_offered++;
            plan_q.delete(0);
          end
          default: begin
            // register writes only go in once the engine has gone quiet
            if (pending_reports_q.size() == 0 && !busy_seen) begin
              hold_cycles = SETTLE_CYCLES;
              plan_q.delete(0);
            end
          end
        endcase
      end
    end
    start     <= nx_start;
    cfg_valid <= nx_cfg;
  end

  // --------------------------------------------------------------- monitor --

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // samples on the rising edge: result words first, then what was taken in
  always @(posedge clk) begin : watch
    result_t want;
    if (rst_n) begin
      busy_seen <= busy;
      if (done) begin
        if (pending_reports_q.size() == 0) begin
          $error("result word with nothing pending: 0x%0h", result);
          fail_cnt++;
        end else begin
          want = pending_reports_q.pop_front();
          check_field("cursor_row", 32'(want.cursor_row), 32'(result.cursor_row));
          check_field("cursor_col", 32'(want.cursor_col), 32'(result.cursor_col));
          check_field("cursor_pos", 32'(want.cursor_pos), 32'(result.cursor_pos));
          check_field("read_data", want.read_data, result.read_data);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_COLS: cols_cfg = cfg_data[GEO_W-1:0];
          CFG_TEXT_ROWS: rows_cfg = cfg_data[GEO_W-1:0];
          CFG_ATTRIBUTE: attr_cfg = cfg_data[ATTR_W-1:0];
          default: ;
        endcase
        cfgs_taken <= cfgs_taken + 1;
      end
      if (start && !busy) begin
        pending_reports_q.push_back(console_report(item));
        items_taken <= items_taken + 1;
      end
    end
  end

  // -------------------------------------------------------------- watchdog --

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= cycle_limit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
